[rtl/rpn_pkg.sv]
// Shared types, command and status codes and helpers of the RPN calculator.
`timescale 1ns / 1ps
`default_nettype none
package rpn_pkg;

  localparam logic [3:0] MODE_PUSH  = 4'd0;
  localparam logic [3:0] MODE_ADD   = 4'd1;
  localparam logic [3:0] MODE_SUB   = 4'd2;
  localparam logic [3:0] MODE_MUL   = 4'd3;
  localparam logic [3:0] MODE_DIV   = 4'd4;
  localparam logic [3:0] MODE_MOD   = 4'd5;
  localparam logic [3:0] MODE_PEEK  = 4'd6;
  localparam logic [3:0] MODE_DUP   = 4'd7;
  localparam logic [3:0] MODE_SWAP  = 4'd8;
  localparam logic [3:0] MODE_CLEAR = 4'd9;
  localparam logic [3:0] MODE_POP   = 4'd10;
  localparam logic [3:0] MODE_STORE = 4'd11;
  localparam logic [3:0] MODE_LOAD  = 4'd12;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_ZERO_DIV   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN    = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL = 3'd5;

  localparam int DVD_W   = 48;
  localparam int DVS_W   = 32;
  localparam int DIV_N_W = 6;

  typedef struct packed {
    logic        [3:0]  mode;
    logic signed [31:0] operand;
    logic        [7:0]  letter;
  } rpn_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               has_result;
    logic        [2:0]  status;
  } rpn_out_t;

  function automatic logic [31:0] sat49(input logic [48:0] v);
    logic [31:0] r;
    if (!v[48] && (|v[47:31])) r = 32'h7FFF_FFFF;
    else if (v[48] && !(&v[47:31])) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/rpn_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rpn_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rpn_pkg::DVD_W-1:0] dvd,
  input  wire logic [rpn_pkg::DVS_W-1:0] dvs,
  output logic                           done,
  output logic      [rpn_pkg::DVD_W-1:0] quo,
  output logic      [rpn_pkg::DVS_W-1:0] rem
);
  import rpn_pkg::*;

  logic [DVD_W-1:0]   q_r;
  logic [DVS_W-1:0]   r_r;
  logic [DVS_W-1:0]   d_r;
  logic [DIV_N_W-1:0] n_r;
  logic               busy_r;
  logic               done_r;
  logic [DVS_W:0]     sh;
  logic [DVS_W+1:0]   diff;
  logic               ge;

  assign sh   = {r_r, q_r[DVD_W-1]};
  assign diff = {1'b0, sh} - {2'b00, d_r};
  assign ge   = !diff[DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      n_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= DIV_N_W'(DVD_W - 1);
      end else if (busy_r) begin
        n_r <= n_r - 1'b1;
        if (n_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dvd;
      r_r <= '0;
      d_r <= dvs;
    end else if (busy_r) begin
      q_r <= {q_r[DVD_W-2:0], ge};
      r_r <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule
`default_nettype wire

[rtl/rpn_stack_calculator_top.sv]
// Top level of the RPN calculator: sequencer, value stack, letter table and arithmetic.
//
// One command at a time: in_stall is high from acceptance until the sequencer is back in
// idle, and the finished word sits in an output register, so the next command can be taken
// while it waits. A multiply is one 32x32 multiply and then a rounding step; div and mod
// wait on the 48-step restoring divider; a zero divisor ends after the first pop. Store and
// load search the letter table linearly through its single read port, one used slot after
// another. A stalled output register holds the sequencer in its last state until the
// previous word is taken.
`timescale 1ns / 1ps
`default_nettype none
module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH  = 128,
  parameter int LETTER_SLOTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rpn_pkg::rpn_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rpn_pkg::rpn_out_t      out_data
);
  import rpn_pkg::*;

  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(LETTER_SLOTS + 1);
  localparam int LW = (LETTER_SLOTS > 1) ? $clog2(LETTER_SLOTS) : 1;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_POPB  = 5'd2;
  localparam logic [4:0] S_GETB  = 5'd3;
  localparam logic [4:0] S_POPA  = 5'd4;
  localparam logic [4:0] S_GETA  = 5'd5;
  localparam logic [4:0] S_EXEC  = 5'd6;
  localparam logic [4:0] S_MULN  = 5'd7;
  localparam logic [4:0] S_DIVW  = 5'd8;
  localparam logic [4:0] S_PUSH  = 5'd9;
  localparam logic [4:0] S_DUPW  = 5'd10;
  localparam logic [4:0] S_SW1   = 5'd11;
  localparam logic [4:0] S_SW2   = 5'd12;
  localparam logic [4:0] S_SW3   = 5'd13;
  localparam logic [4:0] S_PEEK  = 5'd14;
  localparam logic [4:0] S_SRD   = 5'd15;
  localparam logic [4:0] S_SCMP  = 5'd16;
  localparam logic [4:0] S_SDONE = 5'd17;
  localparam logic [4:0] S_LDGET = 5'd18;
  localparam logic [4:0] S_TRD   = 5'd19;
  localparam logic [4:0] S_TGET  = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  logic [4:0]  state_r, state_nxt;
  logic [3:0]  mode_r, mode_nxt;
  logic [31:0] opnd_r, opnd_nxt;
  logic [7:0]  ltr_r, ltr_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] res_r, res_nxt;
  logic        has_r, has_nxt;
  logic        expl_r, expl_nxt;
  logic        popd_r, popd_nxt;
  logic        fnd_r, fnd_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [TW-1:0] top_r, top_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic        out_valid_r;
  rpn_out_t    out_data_r;

  logic [31:0] stk_mem [STACK_DEPTH];
  logic [7:0]  tbl_mem [LETTER_SLOTS];
  logic [31:0] val_mem [LETTER_SLOTS];
  logic          sm_we;
  logic [AW-1:0] sm_addr;
  logic [31:0]   sm_wd;
  logic [31:0]   sm_rd_r;
  logic          lt_we, lv_we;
  logic [LW-1:0] l_addr;
  logic [7:0]    lt_rd_r;
  logic [31:0]   lv_rd_r;

  logic [TW-1:0] tm1, tm2;
  logic [32:0]   sum33;
  logic [47:0]   mq;
  logic [48:0]   mq49;
  logic [31:0]   abs_a, abs_b;
  logic [15:0]   ia, ib;
  logic [16:0]   ia_e, ib_e, abs_ia, abs_ib;
  logic [15:0]   rs16;
  logic [48:0]   dq49;
  logic          dv_start, dv_done;
  logic [DVD_W-1:0] dv_dvd, dv_quo;
  logic [DVS_W-1:0] dv_dvs, dv_rem;
  logic          out_load;

  assign tm1   = top_r - TW'(1);
  assign tm2   = top_r - TW'(2);
  assign sum33 = (mode_r == MODE_SUB) ? ({a_r[31], a_r} - {b_r[31], b_r})
                                      : ({a_r[31], a_r} + {b_r[31], b_r});
  assign mq    = prod_r[63:16] + 48'(prod_r[63] && (|prod_r[15:0]));
  assign mq49  = {mq[47], mq};
  assign abs_a = a_r[31] ? (32'd0 - a_r) : a_r;
  assign abs_b = b_r[31] ? (32'd0 - b_r) : b_r;
  assign ia    = a_r[31:16] + 16'(a_r[31] && (|a_r[15:0]));
  assign ib    = b_r[31:16] + 16'(b_r[31] && (|b_r[15:0]));
  assign ia_e  = {ia[15], ia};
  assign ib_e  = {ib[15], ib};
  assign abs_ia = ia_e[16] ? (17'd0 - ia_e) : ia_e;
  assign abs_ib = ib_e[16] ? (17'd0 - ib_e) : ib_e;
  assign rs16  = ia[15] ? (16'd0 - dv_rem[15:0]) : dv_rem[15:0];
  assign dq49  = (a_r[31] ^ b_r[31]) ? (49'd0 - {1'b0, dv_quo}) : {1'b0, dv_quo};
  assign dv_dvd = (mode_r == MODE_MOD) ? DVD_W'(abs_ia) : {abs_a, 16'h0000};
  assign dv_dvs = (mode_r == MODE_MOD) ? DVS_W'(abs_ib) : abs_b;
  assign dv_start = (state_r == S_EXEC) && (mode_r == MODE_DIV || mode_r == MODE_MOD);

  rpn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .dvd   (dv_dvd),
    .dvs   (dv_dvs),
    .done  (dv_done),
    .quo   (dv_quo),
    .rem   (dv_rem)
  );

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    opnd_nxt  = opnd_r;
    ltr_nxt   = ltr_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    has_nxt   = has_r;
    expl_nxt  = expl_r;
    popd_nxt  = popd_r;
    fnd_nxt   = fnd_r;
    st_nxt    = st_r;
    top_nxt   = top_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    prod_nxt  = prod_r;
    sm_we     = 1'b0;
    sm_addr   = tm1[AW-1:0];
    sm_wd     = res_r;
    lt_we     = 1'b0;
    lv_we     = 1'b0;
    l_addr    = idx_r[LW-1:0];
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_data.mode;
          opnd_nxt  = in_data.operand;
          ltr_nxt   = in_data.letter;
          st_nxt    = ST_OK;
          expl_nxt  = 1'b0;
          has_nxt   = 1'b0;
          res_nxt   = '0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_TRD;
        priority case (mode_r)
          MODE_PUSH: begin
            res_nxt   = opnd_r;
            state_nxt = S_PUSH;
          end
          MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: state_nxt = S_POPB;
          MODE_PEEK, MODE_POP: begin
            expl_nxt = 1'b1;
            if (top_r == '0) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              if (mode_r == MODE_POP) top_nxt = tm1;
              state_nxt = S_PEEK;
            end
          end
          MODE_DUP: begin
            if (top_r == '0) st_nxt = ST_EMPTY;
            else if (top_r == TW'(STACK_DEPTH)) st_nxt = ST_FULL;
            else state_nxt = S_DUPW;
          end
          MODE_SWAP: begin
            if (top_r < TW'(2)) st_nxt = ST_EMPTY;
            else state_nxt = S_SW1;
          end
          MODE_CLEAR: top_nxt = '0;
          MODE_STORE, MODE_LOAD: begin
            idx_nxt   = '0;
            state_nxt = S_SRD;
          end
          default: state_nxt = S_TRD;
        endcase
      end
      S_POPB, S_POPA: begin
        if (top_r != '0) begin
          top_nxt  = tm1;
          popd_nxt = 1'b1;
        end else begin
          popd_nxt = 1'b0;
          st_nxt   = ST_EMPTY;
        end
        state_nxt = (state_r == S_POPB) ? S_GETB : S_GETA;
      end
      S_GETB: begin
        b_nxt     = popd_r ? sm_rd_r : '0;
        state_nxt = S_POPA;
        if (mode_r == MODE_DIV && b_nxt == '0) begin
          st_nxt    = ST_ZERO_DIV;
          state_nxt = S_TRD;
        end else if (mode_r == MODE_MOD && (b_nxt[31:16] == '0 || b_nxt[31:16] == '1)
                     && (b_nxt[31:16] == '0 ? 1'b1 : (b_nxt[15:0] != '0))) begin
          st_nxt    = ST_ZERO_DIV;
          state_nxt = S_TRD;
        end
      end
      S_GETA: begin
        a_nxt     = popd_r ? sm_rd_r : '0;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        priority case (mode_r)
          MODE_ADD, MODE_SUB: begin
            res_nxt   = sat49({{16{sum33[32]}}, sum33});
            state_nxt = S_PUSH;
          end
          MODE_MUL: begin
            prod_nxt  = $signed(a_r) * $signed(b_r);
            state_nxt = S_MULN;
          end
          default: state_nxt = S_DIVW;
        endcase
      end
      S_MULN: begin
        res_nxt   = sat49(mq49);
        state_nxt = S_PUSH;
      end
      S_DIVW: begin
        if (dv_done) begin
          res_nxt   = (mode_r == MODE_MOD) ? {rs16, 16'h0000} : sat49(dq49);
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (top_r < TW'(STACK_DEPTH)) begin
          sm_we   = 1'b1;
          sm_addr = top_r[AW-1:0];
          sm_wd   = res_r;
          top_nxt = top_r + TW'(1);
        end else begin
          st_nxt = ST_FULL;
        end
        state_nxt = expl_r ? S_DONE : S_TRD;
      end
      S_DUPW: begin
        sm_we     = 1'b1;
        sm_addr   = top_r[AW-1:0];
        sm_wd     = sm_rd_r;
        top_nxt   = top_r + TW'(1);
        state_nxt = S_TRD;
      end
      S_SW1: begin
        a_nxt     = sm_rd_r;
        sm_addr   = tm2[AW-1:0];
        state_nxt = S_SW2;
      end
      S_SW2: begin
        sm_we     = 1'b1;
        sm_addr   = tm1[AW-1:0];
        sm_wd     = sm_rd_r;
        state_nxt = S_SW3;
      end
      S_SW3: begin
        sm_we     = 1'b1;
        sm_addr   = tm2[AW-1:0];
        sm_wd     = a_r;
        state_nxt = S_TRD;
      end
      S_PEEK: begin
        res_nxt   = sm_rd_r;
        has_nxt   = 1'b1;
        state_nxt = S_DONE;
      end
      S_SRD: begin
        if (idx_r == cnt_r) begin
          fnd_nxt   = 1'b0;
          state_nxt = S_SDONE;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (lt_rd_r == ltr_r) begin
          fnd_nxt   = 1'b1;
          state_nxt = S_SDONE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SRD;
        end
      end
      S_SDONE: begin
        if (mode_r == MODE_STORE) begin
          state_nxt = S_TRD;
          if (fnd_r) begin
            lv_we = 1'b1;
          end else if (cnt_r < CW'(LETTER_SLOTS)) begin
            l_addr  = cnt_r[LW-1:0];
            lt_we   = 1'b1;
            lv_we   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            st_nxt = ST_TABLE_FULL;
          end
        end else begin
          expl_nxt = 1'b1;
          if (fnd_r) begin
            state_nxt = S_LDGET;
          end else begin
            st_nxt    = ST_UNKNOWN;
            state_nxt = S_DONE;
          end
        end
      end
      S_LDGET: begin
        res_nxt   = lv_rd_r;
        has_nxt   = 1'b1;
        state_nxt = S_PUSH;
      end
      S_TRD: begin
        if (top_r != '0) begin
          state_nxt = S_TGET;
        end else begin
          res_nxt   = '0;
          has_nxt   = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_TGET: begin
        res_nxt   = sm_rd_r;
        has_nxt   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) stk_mem[sm_addr] <= sm_wd;
    sm_rd_r <= stk_mem[sm_addr];
  end

  always_ff @(posedge clk) begin
    if (lt_we) tbl_mem[l_addr] <= ltr_r;
    lt_rd_r <= tbl_mem[l_addr];
  end

  always_ff @(posedge clk) begin
    if (lv_we) val_mem[l_addr] <= opnd_r;
    lv_rd_r <= val_mem[l_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    opnd_r <= opnd_nxt;
    ltr_r  <= ltr_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    has_r  <= has_nxt;
    expl_r <= expl_nxt;
    popd_r <= popd_nxt;
    fnd_r  <= fnd_nxt;
    st_r   <= st_nxt;
    idx_r  <= idx_nxt;
    prod_r <= prod_nxt;
    if (out_load) begin
      out_data_r.result     <= res_r;
      out_data_r.has_result <= has_r;
      out_data_r.status     <= st_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(LETTER_SLOTS))
    else $error("letter count beyond slots");

  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DISP))
    else $error("accepted word not dispatched");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (state_r == S_DIVW))
    else $error("divider finished outside wait state");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result word raised outside done state");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the RPN stack calculator: queued driver, clocked monitor, predictor.
`timescale 1ns / 1ps
module tb_top;
  import rpn_pkg::*;

  localparam int DEPTH = 128;
  localparam int SLOTS = 64;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rpn_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rpn_out_t out_data;

  rpn_stack_calculator_top #(.STACK_DEPTH(DEPTH), .LETTER_SLOTS(SLOTS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  rpn_in_t  cmd_q[$];
  rpn_out_t word_q[$];
  int       hold_q[$];
  int       errors = 0;
  bit       stim_done = 0;

  // predictor state
  logic signed [31:0] stk[DEPTH];
  int                 depth_now = 0;
  logic [7:0]         names[SLOTS];
  logic signed [31:0] vals[SLOTS];
  int                 n_names = 0;

  function automatic logic signed [31:0] clamp(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] take(inout logic [2:0] st);
    if (depth_now > 0) begin
      depth_now--;
      return stk[depth_now];
    end
    st = ST_EMPTY;
    return 0;
  endfunction

  function automatic void put(input logic signed [31:0] v, inout logic [2:0] st);
    if (depth_now < DEPTH) begin
      stk[depth_now] = v;
      depth_now++;
    end else st = ST_FULL;
  endfunction

  function automatic rpn_out_t calc_word(input rpn_in_t c);
    rpn_out_t w;
    logic [2:0] st;
    logic signed [31:0] a, b, r, t, ia, ib;
    bit own, has;
    int slot;
    st = ST_OK; own = 0; has = 0; r = 0; slot = -1;
    for (int i = 0; i < n_names; i++)
      if (slot < 0 && names[i] == c.letter) slot = i;
    case (c.mode)
      MODE_PUSH: put(c.operand, st);
      MODE_ADD: begin
        b = take(st); a = take(st);
        put(clamp(longint'(a) + longint'(b)), st);
      end
      MODE_SUB: begin
        b = take(st); a = take(st);
        put(clamp(longint'(a) - longint'(b)), st);
      end
      MODE_MUL: begin
        b = take(st); a = take(st);
        put(clamp((longint'(a) * longint'(b)) / 65536), st);
      end
      MODE_DIV: begin
        b = take(st);
        if (b == 0) st = ST_ZERO_DIV;
        else begin
          a = take(st);
          put(clamp((longint'(a) * 65536) / longint'(b)), st);
        end
      end
      MODE_MOD: begin
        b = take(st);
        ib = b / 65536;
        if (ib == 0) st = ST_ZERO_DIV;
        else begin
          a = take(st);
          ia = a / 65536;
          put(clamp(longint'(ia % ib) * 65536), st);
        end
      end
      MODE_PEEK: begin
        own = 1;
        if (depth_now > 0) begin r = stk[depth_now-1]; has = 1; end
        else st = ST_EMPTY;
      end
      MODE_DUP: begin
        if (depth_now == 0) st = ST_EMPTY;
        else put(stk[depth_now-1], st);
      end
      MODE_SWAP: begin
        if (depth_now < 2) st = ST_EMPTY;
        else begin
          t = stk[depth_now-1];
          stk[depth_now-1] = stk[depth_now-2];
          stk[depth_now-2] = t;
        end
      end
      MODE_CLEAR: depth_now = 0;
      MODE_POP: begin
        own = 1;
        if (depth_now > 0) begin r = take(st); has = 1; end
        else st = ST_EMPTY;
      end
      MODE_STORE: begin
        if (slot >= 0) vals[slot] = c.operand;
        else if (n_names < SLOTS) begin
          names[n_names] = c.letter; vals[n_names] = c.operand; n_names++;
        end else st = ST_TABLE_FULL;
      end
      MODE_LOAD: begin
        own = 1;
        if (slot >= 0) begin r = vals[slot]; has = 1; put(r, st); end
        else st = ST_UNKNOWN;
      end
      default: ;
    endcase
    if (!own && depth_now > 0) begin r = stk[depth_now-1]; has = 1; end
    if (!has) r = 0;
    w.result = r; w.has_result = has; w.status = st;
    return w;
  endfunction

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      3: return $signed($urandom_range(0, 20) - 10) * 65536;
      4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  function automatic rpn_in_t mk(input logic [3:0] m, input logic signed [31:0] v,
                                 input logic [7:0] l);
    rpn_in_t c;
    c.mode = m; c.operand = v; c.letter = l;
    return c;
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        word_q.push_back(calc_word(in_data));
        void'(cmd_q.pop_front());
      end
      if (in_valid && in_stall) ;
      else if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0 && !(in_valid && !in_stall)) begin
        if (hold_q.size() > 0 && hold_q[0] == 1 && word_q.size() > 0) in_valid <= 1'b0;
        else begin
          if (hold_q.size() > 0) void'(hold_q.pop_front());
          in_data <= cmd_q[0];
          in_valid <= 1'b1;
          gap <= $urandom_range(0, 4) * $urandom_range(0, 1);
        end
      end else if (in_valid && !in_stall) begin
        if (cmd_q.size() > 0 && gap == 0 && !(hold_q.size() > 0 && hold_q[0] == 1)) begin
          if (hold_q.size() > 0) void'(hold_q.pop_front());
          in_data <= cmd_q[0];
          gap <= $urandom_range(0, 4) * $urandom_range(0, 1);
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int out_wait = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (word_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          if (out_data.result !== word_q[0].result) begin
            $error("result exp %0d got %0d", word_q[0].result, out_data.result); errors++;
          end
          if (out_data.has_result !== word_q[0].has_result) begin
            $error("has_result exp %0b got %0b", word_q[0].has_result, out_data.has_result);
            errors++;
          end
          if (out_data.status !== word_q[0].status) begin
            $error("status exp %0d got %0d", word_q[0].status, out_data.status); errors++;
          end
          void'(word_q.pop_front());
        end
        out_wait = $urandom_range(0, 4);
      end else if (out_valid && out_wait > 0) out_wait--;
      out_stall <= (out_wait > 0);
    end
  end

  task automatic add_cmd(input rpn_in_t c, input int hold);
    cmd_q.push_back(c);
    hold_q.push_back(hold);
  endtask

  initial begin
    int m;
    logic [7:0] l;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed
    add_cmd(mk(MODE_POP, 0, 0), 0);
    add_cmd(mk(MODE_PEEK, 0, 0), 0);
    add_cmd(mk(MODE_ADD, 0, 0), 0);
    add_cmd(mk(MODE_DUP, 0, 0), 0);
    add_cmd(mk(MODE_SWAP, 0, 0), 0);
    add_cmd(mk(MODE_LOAD, 0, 8'hFF), 0);
    add_cmd(mk(MODE_PUSH, 32'sh7FFF_FFFF, 0), 0);
    add_cmd(mk(MODE_PUSH, 32'sh7FFF_FFFF, 0), 0);
    add_cmd(mk(MODE_ADD, 0, 0), 0);
    add_cmd(mk(MODE_PUSH, 32'sh8000_0000, 0), 0);
    add_cmd(mk(MODE_MUL, 0, 0), 0);
    add_cmd(mk(MODE_PUSH, 0, 0), 0);
    add_cmd(mk(MODE_DIV, 0, 0), 0);
    add_cmd(mk(MODE_PUSH, 32'sh0000_8000, 0), 0);
    add_cmd(mk(MODE_MOD, 0, 0), 0);
    add_cmd(mk(MODE_PUSH, 32'sh0003_0000, 0), 0);
    add_cmd(mk(MODE_SUB, 0, 0), 0);
    add_cmd(mk(MODE_STORE, 32'sh8000_0000, 8'h00), 0);
    add_cmd(mk(MODE_STORE, 32'sh1234_5678, 8'h00), 0);
    add_cmd(mk(MODE_LOAD, 0, 8'h00), 1);
    add_cmd(mk(4'd15, 0, 0), 0);
    add_cmd(mk(MODE_CLEAR, 0, 0), 0);
    // fill the stack past full, then dup and load onto it
    for (int i = 0; i < DEPTH + 1; i++) add_cmd(mk(MODE_PUSH, rand_val(), 0), 0);
    add_cmd(mk(MODE_DUP, 0, 0), 0);
    add_cmd(mk(MODE_LOAD, 0, 8'h00), 0);
    add_cmd(mk(MODE_CLEAR, 0, 0), 1);
    // fill the table past full
    for (int i = 0; i < SLOTS + 2; i++) add_cmd(mk(MODE_STORE, rand_val(), 8'(i * 3 + 1)), 0);
    // random
    for (int i = 0; i < 1400; i++) begin
      m = $urandom_range(0, 99);
      if (m < 30) m = MODE_PUSH;
      else if (m < 60) m = $urandom_range(1, 5);
      else if (m < 90) m = $urandom_range(6, 12);
      else if (m < 93) m = $urandom_range(13, 15);
      else m = $urandom_range(0, 12);
      l = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12) * 3 + 1);
      add_cmd(mk(4'(m), rand_val(), l), (i % 300 == 299) ? 1 : 0);
    end
    wait (cmd_q.size() == 0);
    stim_done = 1;
  end

  initial begin
    wait (stim_done && word_q.size() == 0 && !in_valid);
    repeat (200) @(posedge clk);
    if (errors == 0 && word_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

[sim.f]
rtl/rpn_pkg.sv
rtl/rpn_div.sv
rtl/rpn_stack_calculator_top.sv
bench/tb_top.sv
